// ===== hdl/aabb_pkg.sv =====
// Shared constants and types for the wall box collision core.
package aabb_pkg;

  localparam int MaxWallsDefault = 64;
  localparam int CoordW = 20;
  localparam int PadXz = 40;
  localparam int PadY = 80;

  // Configuration register indexes
  localparam logic [2:0] RegWallCount = 3'd0;
  localparam logic [2:0] RegGardenX   = 3'd1;
  localparam logic [2:0] RegGardenZ   = 3'd2;
  localparam logic [2:0] RegGardenR   = 3'd3;
  localparam logic [2:0] RegStepSize  = 3'd4;
  localparam logic [2:0] RegLiftLimit = 3'd5;

  // Item kinds
  localparam logic [1:0] KindLoad = 2'd0;
  localparam logic [1:0] KindMove = 2'd1;
  localparam logic [1:0] KindFall = 2'd2;

  // One wall entry: corner and extent
  typedef struct packed {
    logic signed [CoordW-1:0] cz;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] ez;
    logic signed [CoordW-1:0] ey;
    logic signed [CoordW-1:0] ex;
  } wall_t;

endpackage

// ===== hdl/aabb_box_test.sv =====
// Registered overlap test of one probe point against one padded wall box.
module aabb_box_test (
  input  logic                clk,
  input  aabb_pkg::wall_t     wall,
  input  logic signed [19:0]  px,
  input  logic signed [35:0]  py,
  input  logic signed [19:0]  pz,
  output logic                hit
);
  import aabb_pkg::*;

  logic signed [38:0] dx, dy, dz, ax, ay, az, lx, ly, lz;

  // Twice the distance from the box center, against the padded extent
  always_comb begin
    dx = 39'(2 * 39'(wall.cx)) + 39'(wall.ex) - 39'(2 * 39'(px));
    dz = 39'(2 * 39'(wall.cz)) + 39'(wall.ez) - 39'(2 * 39'(pz));
    dy = 39'(2 * 39'(wall.cy)) + 39'(wall.ey) - 39'(2 * 39'(py)) - 39'(PadY);
    ax = dx[38] ? -dx : dx;
    ay = dy[38] ? -dy : dy;
    az = dz[38] ? -dz : dz;
    lx = 39'(wall.ex) + 39'(PadXz);
    ly = 39'(wall.ey) + 39'(PadY);
    lz = 39'(wall.ez) + 39'(PadXz);
  end

  always_ff @(posedge clk) begin
    hit <= (ax < lx) && (ay < ly) && (az < lz);
  end
endmodule

// ===== hdl/aabb_collision_step_up_core.sv =====
// Top level of the wall box collision core with step-up resolution.
// Usage: items arrive on s_axis (tuser = kind), results leave on m_axis.
// A load item writes one wall entry and returns an all-zero beat that is
// valid the cycle after the item is accepted. A move or fall item tests the
// garden circle (one multiplier, reused for dx^2, dz^2, r^2) and then walks
// the wall memory one entry per cycle through one shared box test. Each lift
// candidate runs the garden states S_DX, S_DZ, S_RR and S_CMP, then the walk
// and S_DONE, which tries the next lift or sends the beat; a hit ends a walk
// early once the read pipeline drains.
// One item is worked on at a time; s_axis_tready is low while busy and while
// a result waits in the output register, so the next item is taken the cycle
// after the result beat leaves. Config writes come over cfg_valid/cfg_ready/
// cfg_index/cfg_data; the user must make them idle only, as the block does
// not enforce it. Reset sets control and config registers to reset values;
// wall memory is undefined until loaded. A stalled m_axis holds its beat.
module aabb_collision_step_up_core #(
  parameter int MAX_WALLS = aabb_pkg::MaxWallsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: wall_index[5:0], pos_x, pos_y, pos_z, aux_x, aux_y, aux_z
  input  logic [127:0] s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: res_x, res_y, res_z, reverted, lifted, can_fall
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import aabb_pkg::*;

  localparam int IdxW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CntW = $clog2(MAX_WALLS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DX, S_DZ, S_RR, S_CMP, S_WALK, S_DONE
  } state_t;

  state_t state;
  logic [6:0] wall_count;
  logic signed [19:0] garden_x, garden_z;
  logic [15:0] garden_radius, lift_limit;
  logic [11:0] step_size;

  wall_t mem [MAX_WALLS];
  wall_t rd_wall;

  logic [1:0] kind;
  logic signed [19:0] px, py, pz, ax, ay, az;
  logic [27:0] lift;
  logic signed [35:0] ty;
  logic [CntW:0] rd_cnt, tst_cnt;
  logic [CntW-1:0] nwalls;
  logic any_hit, rd_v, tv;
  logic hit;

  // Shared multiplier for the garden test
  logic signed [20:0] mul_a;
  logic signed [41:0] mul_p;
  logic [42:0] dist_sq;
  always_comb begin
    mul_a = 21'sd0;
    unique case (state)
      S_DX: mul_a = 21'(garden_x) - 21'(px);
      S_DZ: mul_a = 21'(garden_z) - 21'(pz);
      S_RR: mul_a = $signed({5'd0, garden_radius});
      default: mul_a = 21'sd0;
    endcase
  end

  assign nwalls = ({25'd0, wall_count} > 32'(MAX_WALLS)) ? CntW'(MAX_WALLS)
                                                          : CntW'(wall_count);
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign cfg_ready = 1'b1;

  aabb_box_test u_box (
    .clk(clk), .wall(rd_wall), .px(px), .py(ty), .pz(pz), .hit(hit)
  );

  // Wall memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready && s_axis_tuser == KindLoad &&
        {26'd0, s_axis_tdata[5:0]} < 32'(MAX_WALLS))
      mem[IdxW'(s_axis_tdata[5:0])] <= {s_axis_tdata[65:46], s_axis_tdata[45:26],
        s_axis_tdata[25:6], s_axis_tdata[125:106], s_axis_tdata[105:86],
        s_axis_tdata[85:66]} ;
    rd_wall <= mem[IdxW'(rd_cnt[CntW-1:0])];
  end

  logic signed [20:0] ry_sat;
  logic signed [35:0] lifted_y;
  assign lifted_y = 36'(py) + $signed({8'd0, lift});
  assign ry_sat = 21'(lifted_y > 36'sd524287 ? 36'sd524287 : lifted_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      wall_count <= '0; garden_x <= '0; garden_z <= '0;
      garden_radius <= '0; step_size <= 12'd16; lift_limit <= '0;
      rd_v <= 1'b0; tv <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          RegWallCount: wall_count <= cfg_data[6:0];
          RegGardenX:   garden_x <= cfg_data;
          RegGardenZ:   garden_z <= cfg_data;
          RegGardenR:   garden_radius <= cfg_data[15:0];
          RegStepSize:  step_size <= cfg_data[11:0];
          RegLiftLimit: lift_limit <= cfg_data[15:0];
          default: ;
        endcase
      end
      mul_p <= mul_a * mul_a;
      rd_v <= 1'b0; tv <= rd_v;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          kind <= s_axis_tuser;
          pz <= s_axis_tdata[65:46]; py <= s_axis_tdata[45:26];
          px <= s_axis_tdata[25:6];
          az <= s_axis_tdata[125:106]; ay <= s_axis_tdata[105:86];
          ax <= s_axis_tdata[85:66];
          lift <= '0;
          if (s_axis_tuser == KindMove || s_axis_tuser == KindFall) begin
            ty <= (s_axis_tuser == KindFall)
              ? 36'(signed'(s_axis_tdata[45:26])) - 36'(step_size)
              : 36'(signed'(s_axis_tdata[45:26]));
            state <= S_DX;
          end else begin
            m_axis_tdata <= '0;
            m_axis_tvalid <= 1'b1;
          end
        end
        S_DX: state <= S_DZ;
        S_DZ: begin dist_sq <= 43'(mul_p); state <= S_RR; end
        S_RR: begin dist_sq <= dist_sq + 43'(mul_p); state <= S_CMP; end
        S_CMP: begin
          any_hit <= dist_sq < 43'(mul_p);
          rd_cnt <= '0; tst_cnt <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          // issue reads, then fold in registered box results
          if (rd_cnt < (CntW+1)'(nwalls) && !any_hit) begin
            rd_v <= 1'b1; rd_cnt <= rd_cnt + 1'b1;
          end
          if (tv) begin
            tst_cnt <= tst_cnt + 1'b1;
            if (hit) any_hit <= 1'b1;
          end
          if ((any_hit || (tv && hit)) ? !rd_v && !tv
              : (tst_cnt + (CntW+1)'(tv)) == (CntW+1)'(nwalls) && !rd_v &&
                rd_cnt == (CntW+1)'(nwalls))
            state <= S_DONE;
        end
        S_DONE: begin
          if (kind == KindFall) begin
            m_axis_tdata <= {1'b0 ^ !any_hit, 63'd0} >> 1;
            m_axis_tvalid <= 1'b1; state <= S_IDLE;
          end else if (!any_hit) begin
            m_axis_tdata <= {1'b0, 1'b0, (lift != 0), 1'b0, pz, ry_sat[19:0], px};
            m_axis_tvalid <= 1'b1; state <= S_IDLE;
          end else if (step_size != 0 &&
                       (lift + 28'(step_size)) < 28'(lift_limit)) begin
            lift <= lift + 28'(step_size);
            ty <= 36'(py) + $signed({8'd0, lift + 28'(step_size)});
            state <= S_DX;
          end else begin
            m_axis_tdata <= {1'b0, 1'b0, 1'b0, 1'b1, az, ay, ax};
            m_axis_tvalid <= 1'b1; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== test/aabb_collision_step_up_core_test.sv =====
// Testbench for the wall box collision core: streaming stimulus, scoreboard and predictor.
`timescale 1ns / 1ps

module aabb_collision_step_up_core_test;
  import aabb_pkg::*;

  localparam int NumWalls = 64;
  localparam int NumPhases = 6;
  localparam int PhaseItems = 250;
  localparam longint CycleLimit = 64'd20000000;
  // Kind code with no operation
  localparam logic [1:0] KindOther = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [5:0] idx;
    logic signed [19:0] px, py, pz, ax, ay, az;
  } item_t;

  typedef struct {
    logic signed [19:0] rx, ry, rz;
    logic rev, lif, fall;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // tdata: wall_index[5:0], pos_x, pos_y, pos_z, aux_x, aux_y, aux_z
  logic [127:0] s_axis_tdata = '0;
  // tuser: kind[1:0]
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // tdata: res_x, res_y, res_z, reverted, lifted, can_fall
  logic [63:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  aabb_collision_step_up_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: wall table and register copies
  longint wall_c[NumWalls][3];
  longint wall_e[NumWalls][3];
  longint n_walls = 0, gard_x = 0, gard_z = 0, gard_r = 0, step = 16, lift_max = 0;

  item_t pending[$];
  outcome_t outcome_q[$];
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 1'b0;
  int mismatches = 0;
  longint cycles = 0;

  function automatic bit blocked(longint px, longint py, longint pz);
    longint dx, dz, n;
    bit mx, my, mz;
    dx = gard_x - px;
    dz = gard_z - pz;
    n = (n_walls > NumWalls) ? NumWalls : n_walls;
    if (dx * dx + dz * dz < gard_r * gard_r) return 1'b1;
    for (int i = 0; i < n; i++) begin
      mx = abs_l(2 * wall_c[i][0] + wall_e[i][0] - 2 * px) < wall_e[i][0] + PadXz;
      mz = abs_l(2 * wall_c[i][2] + wall_e[i][2] - 2 * pz) < wall_e[i][2] + PadXz;
      my = abs_l(2 * wall_c[i][1] + wall_e[i][1] - 2 * py - PadY) < wall_e[i][1] + PadY;
      if (mx && my && mz) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [19:0] clamp20(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[19:0];
  endfunction

  // Expected beat for one accepted item; updates the wall table on loads
  function automatic outcome_t resolve(item_t it);
    outcome_t o;
    longint lift;
    bit found;
    o = '{default: '0};
    found = 1'b0;
    case (it.kind)
      KindLoad: begin
        wall_c[it.idx] = '{it.px, it.py, it.pz};
        wall_e[it.idx] = '{it.ax, it.ay, it.az};
      end
      KindMove: begin
        if (!blocked(it.px, it.py, it.pz)) begin
          o.rx = it.px; o.ry = it.py; o.rz = it.pz;
        end else begin
          lift = step;
          if (step > 0) begin
            while (lift < lift_max && !found) begin
              if (!blocked(it.px, longint'(it.py) + lift, it.pz)) found = 1'b1;
              else lift += step;
            end
          end
          if (found) begin
            o.rx = it.px; o.ry = clamp20(longint'(it.py) + lift); o.rz = it.pz;
            o.lif = 1'b1;
          end else begin
            o.rx = it.ax; o.ry = it.ay; o.rz = it.az;
            o.rev = 1'b1;
          end
        end
      end
      KindFall: o.fall = !blocked(it.px, longint'(it.py) - step, it.pz);
      default: ;
    endcase
    return o;
  endfunction

  // Driver: one beat per handshake, expectation formed when the beat is loaded
  always @(posedge clk) begin
    item_t it;
    cycles <= cycles + 1;
    if (!rst && !(s_axis_tvalid && !s_axis_tready)) begin
      if (pending.size() > 0 && !hold_off && $urandom_range(99) >= send_idle) begin
        it = pending.pop_front();
        s_axis_tdata <= {2'b0, it.az, it.ay, it.ax, it.pz, it.py, it.px, it.idx};
        s_axis_tuser <= it.kind;
        s_axis_tvalid <= 1'b1;
        outcome_q.push_back(resolve(it));
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and field compare against the oldest expectation
  always @(posedge clk) begin
    outcome_t e;
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall);
    if (m_axis_tvalid && m_axis_tready) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        e = outcome_q.pop_front();
        if (m_axis_tdata[19:0] !== e.rx || m_axis_tdata[39:20] !== e.ry ||
            m_axis_tdata[59:40] !== e.rz || m_axis_tdata[60] !== e.rev ||
            m_axis_tdata[61] !== e.lif || m_axis_tdata[62] !== e.fall ||
            m_axis_tdata[63] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d z=%0d rev=%b lif=%b fall=%b, got %h",
                     e.rx, e.ry, e.rz, e.rev, e.lif, e.fall, m_axis_tdata);
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegWallCount: n_walls = val[6:0];
      RegGardenX:   gard_x = $signed(val);
      RegGardenZ:   gard_z = $signed(val);
      RegGardenR:   gard_r = val[15:0];
      RegStepSize:  step = val[11:0];
      RegLiftLimit: lift_max = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending.size() > 0 || s_axis_tvalid || outcome_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [19:0] rnd(int lo, int hi);
    return 20'($urandom_range(hi - lo) + lo);
  endfunction

  function automatic item_t wall_item(logic [5:0] idx);
    item_t it;
    it.kind = KindLoad; it.idx = idx;
    it.px = rnd(-1500, 1500); it.py = rnd(-200, 200); it.pz = rnd(-1500, 1500);
    it.ax = rnd(16, 600); it.ay = rnd(16, 300); it.az = rnd(16, 600);
    if ($urandom_range(9) == 0) it.ay = rnd(-300, -1);
    if ($urandom_range(9) == 0) it.ax = rnd(-300, -1);
    if ($urandom_range(19) == 0) begin
      it.px = 20'($urandom); it.py = 20'($urandom); it.pz = 20'($urandom);
      it.ax = 20'($urandom); it.ay = 20'($urandom); it.az = 20'($urandom);
    end
    return it;
  endfunction

  function automatic item_t query_item();
    item_t it;
    int r;
    r = $urandom_range(99);
    it.kind = (r < 8) ? KindLoad : (r < 60) ? KindMove : (r < 97) ? KindFall : KindOther;
    it.idx = 6'($urandom);
    if (it.kind == KindLoad) return wall_item(it.idx);
    it.px = rnd(-1800, 1800); it.py = rnd(-300, 500); it.pz = rnd(-1800, 1800);
    it.ax = 20'($urandom); it.ay = 20'($urandom); it.az = 20'($urandom);
    if ($urandom_range(19) == 0) begin
      it.px = 20'($urandom); it.py = 20'($urandom); it.pz = 20'($urandom);
    end
    return it;
  endfunction

  function automatic item_t mk(logic [1:0] k, logic [5:0] i, int px, int py, int pz,
                               int ax, int ay, int az);
    item_t it;
    it.kind = k; it.idx = i;
    it.px = 20'(px); it.py = 20'(py); it.pz = 20'(pz);
    it.ax = 20'(ax); it.ay = 20'(ay); it.az = 20'(az);
    return it;
  endfunction

  // Phase settings: wall_count, garden x/z/r, step, lift limit, idling
  int p_wc[NumPhases]   = '{8, 64, 0, 100, 20, 64};
  int p_gx[NumPhases]   = '{0, 524287, -524288, 300, -200, 0};
  int p_gz[NumPhases]   = '{0, -524288, 524287, -300, 200, 0};
  int p_gr[NumPhases]   = '{0, 65535, 0, 400, 800, 100};
  int p_st[NumPhases]   = '{16, 4095, 1, 40, 0, 64};
  int p_lim[NumPhases]  = '{200, 65535, 20, 320, 100, 0};
  int p_send[NumPhases] = '{0, 57, 0, 12, 57, 0};
  int p_recv[NumPhases] = '{0, 0, 57, 12, 57, 0};

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    reg_write(RegWallCount, 20'd64);
    reg_write(RegLiftLimit, 20'd160);

    // Fill every wall entry so no query reads an unloaded one
    for (int i = 0; i < NumWalls; i++) pending.push_back(wall_item(6'(i)));
    drain();

    // Directed: box at origin, free and blocked moves, lifts, falls, odd kind
    pending.push_back(mk(KindLoad, 0, 0, 0, 0, 160, 160, 160));
    pending.push_back(mk(KindMove, 0, 5000, 0, 5000, 1, 2, 3));
    pending.push_back(mk(KindMove, 0, 80, 0, 80, 1, 2, 3));
    pending.push_back(mk(KindMove, 0, 80, 100, 80, -7, 8, -9));
    pending.push_back(mk(KindFall, 0, 80, 260, 80, 0, 0, 0));
    pending.push_back(mk(KindFall, 0, 80, 600, 80, 0, 0, 0));
    pending.push_back(mk(KindFall, 0, 9000, 0, 9000, 0, 0, 0));
    pending.push_back(mk(KindOther, 63, -1, -1, -1, -1, -1, -1));
    pending.push_back(mk(KindLoad, 63, -524288, -524288, -524288, -524288, -524288, -524288));
    pending.push_back(mk(KindLoad, 62, 524287, 524287, 524287, 524287, 524287, 524287));
    pending.push_back(mk(KindMove, 5, 524287, 524287, 524287, -524288, 524287, -524288));
    pending.push_back(mk(KindMove, 6, -524288, -524288, -524288, 524287, -524288, 524287));
    pending.push_back(mk(KindFall, 7, -524288, -524288, -524288, 0, 0, 0));
    pending.push_back(mk(KindLoad, 1, 0, 0, 0, -100, -100, -100));
    pending.push_back(mk(KindMove, 0, 80, 524280, 80, 0, 0, 0));
    drain();

    // Random phases over several register settings and idling mixes
    for (int ph = 0; ph < NumPhases; ph++) begin
      reg_write(RegWallCount, 20'(p_wc[ph]));
      reg_write(RegGardenX, 20'(p_gx[ph]));
      reg_write(RegGardenZ, 20'(p_gz[ph]));
      reg_write(RegGardenR, 20'(p_gr[ph]));
      reg_write(RegStepSize, 20'(p_st[ph]));
      reg_write(RegLiftLimit, 20'(p_lim[ph]));
      send_idle = p_send[ph];
      recv_stall = p_recv[ph];
      for (int n = 0; n < PhaseItems; n++) pending.push_back(query_item());
      if (ph == 1) begin
        // Sender holds off until every outstanding result is back
        while (pending.size() > PhaseItems / 2) @(posedge clk);
        hold_off = 1'b1;
        while (s_axis_tvalid || outcome_q.size() > 0) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
